>>> sv/fs_pkg.sv
`default_nettype none

package fs_pkg;

    // Fixed field widths
    localparam int TIME_W  = 48;
    localparam int COUNT_W = 16;
    localparam int BATT_W  = 10;
    localparam int TMO_W   = 16;
    localparam int THR_W   = 26;  // timeout in microseconds, 65535 * 1000 fits
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [THR_W-1:0] US_PER_MS = THR_W'(1000);

    // Register reset values
    localparam logic [TMO_W-1:0]  GPS_TIMEOUT_RESET = TMO_W'(5000);
    localparam logic [BATT_W-1:0] LOW_BATT_RESET    = BATT_W'(200);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GPS_TIMEOUT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LOW_BATT    = CFG_IDX_W'(1);

    // Operation codes
    localparam logic [1:0] OP_CHECK = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_STAMP = 2'd2;

    // Reason codes
    localparam logic [1:0] R_NONE = 2'd0;
    localparam logic [1:0] R_COMM = 2'd1;
    localparam logic [1:0] R_GPS  = 2'd2;
    localparam logic [1:0] R_BATT = 2'd3;

    typedef struct packed {
        logic [1:0]        operation;
        logic [TIME_W-1:0] now_us;
        logic              link_lost;
        logic              gps_ready;
        logic [BATT_W-1:0] battery_tenths;
    } t_in_item;

    typedef struct packed {
        logic               rtl_request;
        logic               loiter_request;
        logic               failsafe_on;
        logic [1:0]         reason_code;
        logic [COUNT_W-1:0] comm_loss_ticks;
        logic [COUNT_W-1:0] gps_loss_ticks;
    } t_out_item;

    // Configuration as seen by the supervisor core
    typedef struct packed {
        logic [THR_W-1:0]  gps_timeout_us;
        logic [BATT_W-1:0] low_battery_tenths;
    } t_cfg;

endpackage

`default_nettype wire

>>> sv/fs_cfg.sv
`default_nettype none

module fs_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_wr,
    input  wire logic [fs_pkg::CFG_IDX_W-1:0]  i_index,
    input  wire logic [fs_pkg::CFG_DATA_W-1:0] i_data,
    output fs_pkg::t_cfg                       o_cfg
);
    import fs_pkg::*;

    logic [THR_W-1:0]  r_thr_us, n_thr_us;
    logic [BATT_W-1:0] r_low_batt, n_low_batt;

    // Timeout is kept in microseconds so the check path is a subtract and compare
    always_comb begin
        n_thr_us   = r_thr_us;
        n_low_batt = r_low_batt;
        if (i_wr) begin
            if (i_index == REG_GPS_TIMEOUT) begin
                n_thr_us = THR_W'(i_data[TMO_W-1:0]) * US_PER_MS;
            end else if (i_index == REG_LOW_BATT) begin
                n_low_batt = i_data[BATT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_us   <= THR_W'(GPS_TIMEOUT_RESET) * US_PER_MS;
            r_low_batt <= LOW_BATT_RESET;
        end else begin
            r_thr_us   <= n_thr_us;
            r_low_batt <= n_low_batt;
        end
    end

    assign o_cfg.gps_timeout_us     = r_thr_us;
    assign o_cfg.low_battery_tenths = r_low_batt;

endmodule

`default_nettype wire

>>> sv/fs_core.sv
`default_nettype none

module fs_core (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_step,
    input  fs_pkg::t_in_item i_item,
    input  fs_pkg::t_cfg  i_cfg,
    output fs_pkg::t_out_item o_result
);
    import fs_pkg::*;

    logic               r_active, n_active;
    logic [1:0]         r_reason, n_reason;
    logic [TIME_W-1:0]  r_last_fix, n_last_fix;
    logic [COUNT_W-1:0] r_comm_cnt, n_comm_cnt;
    logic [COUNT_W-1:0] r_gps_cnt, n_gps_cnt;

    logic [TIME_W-1:0]  age;
    logic               gps_stale;
    logic               hit_comm, hit_gps, hit_batt;
    logic               want_rtl;
    logic [1:0]         kind;
    logic               rtl, loiter;

    // Fix age wraps with the time base
    assign age       = i_item.now_us - r_last_fix;
    assign gps_stale = age > TIME_W'(i_cfg.gps_timeout_us);

    // A reason counts only when it is not already the active one
    assign hit_comm = i_item.link_lost && (!r_active || r_reason != R_COMM);
    assign hit_gps  = !i_item.gps_ready && gps_stale
                      && (!r_active || r_reason != R_GPS);
    assign hit_batt = (i_item.battery_tenths < i_cfg.low_battery_tenths)
                      && (!r_active || r_reason != R_BATT);
    assign want_rtl = hit_comm || hit_batt;

    // Last one found in check order is recorded
    always_comb begin
        priority if (hit_batt) begin
            kind = R_BATT;
        end else if (hit_gps) begin
            kind = R_GPS;
        end else if (hit_comm) begin
            kind = R_COMM;
        end else begin
            kind = R_NONE;
        end
    end

    // Next state for one operation
    always_comb begin
        n_active   = r_active;
        n_reason   = r_reason;
        n_last_fix = r_last_fix;
        n_comm_cnt = r_comm_cnt;
        n_gps_cnt  = r_gps_cnt;
        rtl        = 1'b0;
        loiter     = 1'b0;
        unique case (i_item.operation)
            OP_CHECK: begin
                if (i_item.link_lost) begin
                    n_comm_cnt = (r_comm_cnt == '1) ? r_comm_cnt : r_comm_cnt + 1'b1;
                end else begin
                    n_comm_cnt = '0;
                end
                if (i_item.gps_ready) begin
                    n_last_fix = i_item.now_us;
                    n_gps_cnt  = '0;
                end else if (gps_stale) begin
                    n_gps_cnt = (r_gps_cnt == '1) ? r_gps_cnt : r_gps_cnt + 1'b1;
                end
                if (want_rtl) begin
                    rtl      = 1'b1;
                    n_active = 1'b1;
                    n_reason = kind;
                end else if (hit_gps && !r_active) begin
                    loiter   = 1'b1;
                    n_active = 1'b1;
                    n_reason = kind;
                end
            end
            OP_CLEAR: begin
                n_active = 1'b0;
                n_reason = R_NONE;
            end
            OP_STAMP: begin
                n_last_fix = i_item.now_us;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_reason   <= R_NONE;
            r_last_fix <= '0;
            r_comm_cnt <= '0;
            r_gps_cnt  <= '0;
        end else if (i_step) begin
            r_active   <= n_active;
            r_reason   <= n_reason;
            r_last_fix <= n_last_fix;
            r_comm_cnt <= n_comm_cnt;
            r_gps_cnt  <= n_gps_cnt;
        end
    end

    // Result shows the state after the item
    assign o_result.rtl_request     = rtl;
    assign o_result.loiter_request  = loiter;
    assign o_result.failsafe_on     = n_active;
    assign o_result.reason_code     = n_reason;
    assign o_result.comm_loss_ticks = n_comm_cnt;
    assign o_result.gps_loss_ticks  = n_gps_cnt;

endmodule

`default_nettype wire

>>> sv/failsafe_supervisor.sv
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+----------------------------------
// in       | input     | i_in_valid / o_in_ready   | i_in  (fs_pkg::t_in_item)
// out      | output    | o_out_valid / i_out_ready | o_out (fs_pkg::t_out_item)
// cfg      | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One request per cycle sustained while the output is not stalled; a request passes
// through the input register, then the check logic loads its result into the result register.
// Supervisor state updates as the request leaves the input register, so the
// next request sees it directly. Reset (synchronous, active low) clears all
// state and loads the default timeout and battery threshold. A stalled output
// holds the result; the input register refills while the result waits.
`default_nettype none

module failsafe_supervisor (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  fs_pkg::t_in_item                   i_in,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output fs_pkg::t_out_item                  o_out,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [fs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [fs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fs_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      advance;
    logic      cfg_wr;
    t_cfg      w_cfg;
    t_out_item w_result;

    // Pipeline control
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    fs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cfg_wr),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    fs_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Accepted request lands in the input register
    a_in_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_in_valid)
        else $error("accepted request not held in input register");

    // A waiting request keeps its contents until the core takes it
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in)))
        else $error("waiting request lost or changed");

    // Core step always produces a result next cycle
    a_step_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("stepped request produced no result");

    // Timeout write is converted to microseconds
    a_cfg_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && i_cfg_index == REG_GPS_TIMEOUT)
        |=> (w_cfg.gps_timeout_us == THR_W'($past(i_cfg_data[TMO_W-1:0])) * US_PER_MS))
        else $error("timeout register not loaded in microseconds");

endmodule

`default_nettype wire
